// ===== hw/rtl/lpvi_pkg.sv =====
// Shared constants, types and fixed-point helpers for the LPV one-step inverse estimator.
// Used by the multiplier, the divider and the top level; depends on nothing else.
package lpvi_pkg;

  localparam int STATE_DIM   = 4;
  localparam int MODEL_SLOTS = 8;
  localparam int FRAC_BITS   = 16;

  localparam int SLOT_W    = 3;
  localparam int OFF_W     = 5;
  localparam int ADDR_W    = SLOT_W + OFF_W;
  localparam int MEM_DEPTH = MODEL_SLOTS * (1 << OFF_W);

  localparam logic [OFF_W-1:0] B_OFF    = OFF_W'(STATE_DIM * STATE_DIM);
  localparam logic [OFF_W-1:0] C_OFF    = OFF_W'(STATE_DIM * STATE_DIM + STATE_DIM);
  localparam logic [OFF_W-1:0] LAST_OFF = OFF_W'(STATE_DIM * STATE_DIM + 2 * STATE_DIM - 1);

  localparam int MUL_W     = 33;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int DIV_W     = 64;
  localparam int DIV_BITS  = 33;
  localparam int DIV_CNT_W = 6;
  localparam int HI_SHIFT  = DIV_BITS - FRAC_BITS;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  typedef enum logic [1:0] {
    CMD_COEF    = 2'd0,
    CMD_PARAM   = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_PROCESS = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    SEL_A = 2'd0,
    SEL_B = 2'd1,
    SEL_C = 2'd2
  } sel_e;

  typedef enum logic [1:0] {
    REG_LAMBDA = 2'd0,
    REG_COUNT  = 2'd1
  } reg_e;

  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
  } div_status_t;

  function automatic logic signed [MUL_W-1:0] sx33(input logic [31:0] x);
    return {x[31], x};
  endfunction

  function automatic logic signed [63:0] sx64(input logic [31:0] x);
    return {{32{x[31]}}, x};
  endfunction

  // Product shifted down by the fraction width, rounding toward minus infinity.
  function automatic logic signed [63:0] fshift(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = p >>> FRAC_BITS;
    return s[63:0];
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] x);
    logic [31:0] r;
    if (x > S32_MAX) r = 32'h7fff_ffff;
    else if (x < S32_MIN) r = 32'h8000_0000;
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic ovf32(input logic signed [63:0] x);
    return (x > S32_MAX) || (x < S32_MIN);
  endfunction

endpackage

// ===== hw/rtl/lpvi_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on lpvi_pkg for the operand width.
module lpvi_mul import lpvi_pkg::*; (
  input  logic                     clk_i,
  input  logic signed [MUL_W-1:0]  a_i,
  input  logic signed [MUL_W-1:0]  b_i,
  output logic signed [PROD_W-1:0] p_o
);

  logic signed [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ===== hw/rtl/lpvi_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by the weight and estimate divisions.
// Depends on lpvi_pkg for widths and the status struct.
module lpvi_div import lpvi_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIV_W-1:0]     rem_i,
  input  logic [DIV_BITS-1:0]  low_i,
  input  logic [DIV_CNT_W-1:0] steps_i,
  input  logic [DIV_W-1:0]     den_i,
  output div_status_t          status_o,
  output logic [DIV_BITS-1:0]  quo_o
);

  logic [DIV_W-1:0]     rem_q;
  logic [DIV_BITS-1:0]  low_q;
  logic [DIV_W-1:0]     den_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_BITS-1:0]  quo_q;
  logic                 busy_q, done_q, ovf_q;

  logic [DIV_W:0] trial, diff;
  logic           ge;

  always_comb begin
    trial = {rem_q, low_q[DIV_BITS-1]};
    ge    = trial >= {1'b0, den_q};
    diff  = trial - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ovf_q  <= 1'b0;
      rem_q  <= '0;
      low_q  <= '0;
      den_q  <= '0;
      cnt_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= rem_i;
        low_q  <= low_i;
        den_q  <= den_i;
        cnt_q  <= steps_i;
        quo_q  <= '0;
        // A leading part already at or above the divisor means the quotient overflows.
        ovf_q  <= rem_i >= den_i;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        low_q <= low_q << 1;
        quo_q <= {quo_q[DIV_BITS-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign status_o = '{busy: busy_q, done: done_q, ovf: ovf_q};
  assign quo_o    = quo_q;

endmodule

// ===== hw/rtl/lpv_one_step_inverse_estimator.sv =====
// One-step inverse estimator for an interpolated SISO state-space model, Q16.16.
// A process item runs two slot scans, each with a weight division when a value falls between
// slots, then interpolates every A, B and C coefficient through the single coefficient memory
// read port and the shared multiplier, forms the dot products, the divisor and the numerator,
// runs the estimate division that a zero divisor skips, and updates the state.
// Load and clear items finish in the cycle they are taken. busy stays high while a process
// item runs, and the result appears on done_o for exactly one cycle; the receiver must take it
// then, as it cannot stall. Depends on lpvi_pkg, lpvi_mul and lpvi_div.
module lpv_one_step_inverse_estimator import lpvi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [30:0] cfg_wdata_i,
  input  logic [1:0]  command_i,
  input  logic [2:0]  slot_index_i,
  input  logic [1:0]  matrix_select_i,
  input  logic [1:0]  row_index_i,
  input  logic [1:0]  col_index_i,
  input  logic [31:0] load_value_i,
  input  logic [31:0] target_next_i,
  input  logic [31:0] param_current_i,
  input  logic [31:0] param_next_i,
  output logic        done_o,
  output logic [31:0] required_input_o,
  output logic        table_empty_o,
  output logic        divide_fault_o,
  output logic        saturated_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_LOC, ST_LOC_DIV, ST_RD_LO, ST_RD_HI, ST_LERP_MUL, ST_LERP_ADD,
    ST_MAC_MUL, ST_MAC_ADD, ST_DOT_MUL, ST_DOT_ADD, ST_BVAL, ST_DEN_MUL, ST_NUM_MUL,
    ST_DIV_START, ST_DIV_WAIT, ST_UPD_MUL, ST_UPD_ADD
  } state_e;

  state_e state_q;

  logic [30:0] regularization_q;
  logic [3:0]  point_count_q;

  logic [31:0] v_q  [STATE_DIM];
  logic [31:0] w_q  [STATE_DIM];
  logic [31:0] bc_q [STATE_DIM];
  logic [31:0] cr_q [STATE_DIM];
  logic [31:0] sp_q [MODEL_SLOTS];
  logic [31:0] mem_q [MEM_DEPTH];
  logic [31:0] mem_rdata_q;

  logic [SLOT_W-1:0] lo_q [2];
  logic [SLOT_W-1:0] hi_q [2];
  logic [15:0]       t_q  [2];

  logic [3:0]       k_q, n_q;
  logic [31:0]      prev_q;
  logic             loc_sel_q;
  logic [31:0]      target_q, pcur_q, pnext_q;
  logic [OFF_W-1:0] off_q;
  logic [1:0]       idx_q;
  logic             dsel_q;
  logic [31:0]      c0_q, coef_q, m_q, y_q, bv_q, x_q;
  logic [63:0]      acc_q, den_q;
  logic             neg_q, sat_q, fault_q;

  logic        done_q, empty_q, dfault_q, osat_q;
  logic [31:0] result_q;

  // Multiplier and divider hookup.
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [63:0]       fs;

  logic                 div_start;
  logic [DIV_W-1:0]     div_rem, div_den;
  logic [DIV_BITS-1:0]  div_low;
  logic [DIV_CNT_W-1:0] div_steps;
  div_status_t          div_st;
  logic [DIV_BITS-1:0]  div_quo;

  lpvi_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  lpvi_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .rem_i    (div_rem),
    .low_i    (div_low),
    .steps_i  (div_steps),
    .den_i    (div_den),
    .status_o (div_st),
    .quo_o    (div_quo)
  );

  logic accept;
  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);

  // Coefficient memory addressing.
  logic              cset;
  logic [SLOT_W-1:0] rd_slot;
  logic [ADDR_W-1:0] mem_raddr, mem_waddr;
  logic [OFF_W-1:0]  wr_off;
  logic              mem_we;

  always_comb begin
    cset      = (off_q >= C_OFF);
    rd_slot   = (state_q == ST_RD_HI) ? hi_q[cset] : lo_q[cset];
    mem_raddr = {rd_slot, off_q};
    case (matrix_select_i)
      SEL_A:   wr_off = {1'b0, row_index_i, col_index_i};
      SEL_B:   wr_off = B_OFF + OFF_W'(row_index_i);
      SEL_C:   wr_off = C_OFF + OFF_W'(col_index_i);
      default: wr_off = '0;
    endcase
    mem_waddr = {slot_index_i, wr_off};
    mem_we    = accept && (command_i == CMD_COEF) &&
                (matrix_select_i == SEL_A || matrix_select_i == SEL_B ||
                 matrix_select_i == SEL_C);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= load_value_i;
    mem_rdata_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (accept && command_i == CMD_PARAM) sp_q[slot_index_i] <= load_value_i;
  end

  // Slot scan.
  logic [31:0] scan_p, scan_cur;
  logic        scan_go;
  logic [32:0] scan_num, scan_den;

  always_comb begin
    scan_p   = loc_sel_q ? pnext_q : pcur_q;
    scan_cur = sp_q[k_q[SLOT_W-1:0]];
    scan_go  = (k_q < n_q) && ($signed(scan_cur) < $signed(scan_p));
    scan_num = {scan_p[31], scan_p} - {prev_q[31], prev_q};
    scan_den = {scan_cur[31], scan_cur} - {prev_q[31], prev_q};
  end

  // Estimate division operands.
  logic signed [PROD_W-1:0] nprod;
  logic [63:0]              mag;
  logic                     pneg;

  always_comb begin
    pneg  = prod[PROD_W-1];
    nprod = -prod;
    mag   = pneg ? nprod[63:0] : prod[63:0];
  end

  logic scan_div;
  assign scan_div = (state_q == ST_LOC) && !scan_go && (k_q != 4'd0) && (k_q != n_q) &&
                    (scan_cur != scan_p);

  always_comb begin
    div_start = 1'b0;
    div_rem   = '0;
    div_low   = '0;
    div_steps = '0;
    div_den   = '0;
    if (scan_div) begin
      div_start = 1'b1;
      div_rem   = DIV_W'(scan_num);
      div_steps = DIV_CNT_W'(FRAC_BITS);
      div_den   = DIV_W'(scan_den);
    end else if (state_q == ST_DIV_START && den_q != '0) begin
      div_start = 1'b1;
      div_rem   = mag >> HI_SHIFT;
      div_low   = DIV_BITS'(mag << FRAC_BITS);
      div_steps = DIV_CNT_W'(DIV_BITS);
      div_den   = den_q;
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_LERP_MUL: begin
        mul_a = sx33(mem_rdata_q) - sx33(c0_q);
        mul_b = MUL_W'(t_q[cset]);
      end
      ST_MAC_MUL: begin
        mul_a = sx33(coef_q);
        mul_b = sx33(v_q[off_q[1:0]]);
      end
      ST_DOT_MUL: begin
        mul_a = sx33(cr_q[idx_q]);
        mul_b = dsel_q ? sx33(w_q[idx_q]) : sx33(bc_q[idx_q]);
      end
      ST_DEN_MUL: begin
        mul_a = sx33(m_q);
        mul_b = sx33(m_q);
      end
      ST_NUM_MUL: begin
        mul_a = sx33(m_q);
        mul_b = sx33(bv_q);
      end
      ST_UPD_MUL: begin
        mul_a = sx33(bc_q[idx_q]);
        mul_b = sx33(x_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign fs = fshift(prod);

  logic signed [63:0] acc_new, bdiff, vsum;
  logic [31:0]        coef;
  logic               qbig;

  always_comb begin
    acc_new = acc_q + fs;
    coef    = c0_q + fs[31:0];
    bdiff   = sx64(target_q) - sx64(y_q);
    vsum    = sx64(w_q[idx_q]) + fs;
    qbig    = div_st.ovf || div_quo[DIV_BITS-1] || (div_quo[31] && (|div_quo[30:0])) ||
              (!neg_q && div_quo[31]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      regularization_q <= 31'd1;
      point_count_q    <= '0;
      for (int i = 0; i < STATE_DIM; i++) begin
        v_q[i]  <= '0;
        w_q[i]  <= '0;
        bc_q[i] <= '0;
        cr_q[i] <= '0;
      end
      for (int s = 0; s < 2; s++) begin
        lo_q[s] <= '0;
        hi_q[s] <= '0;
        t_q[s]  <= '0;
      end
      k_q       <= '0;
      n_q       <= '0;
      prev_q    <= '0;
      loc_sel_q <= 1'b0;
      target_q  <= '0;
      pcur_q    <= '0;
      pnext_q   <= '0;
      off_q     <= '0;
      idx_q     <= '0;
      dsel_q    <= 1'b0;
      c0_q      <= '0;
      coef_q    <= '0;
      m_q       <= '0;
      y_q       <= '0;
      bv_q      <= '0;
      x_q       <= '0;
      acc_q     <= '0;
      den_q     <= '0;
      neg_q     <= 1'b0;
      sat_q     <= 1'b0;
      fault_q   <= 1'b0;
      done_q    <= 1'b0;
      empty_q   <= 1'b0;
      dfault_q  <= 1'b0;
      osat_q    <= 1'b0;
      result_q  <= '0;
    end else begin
      done_q <= 1'b0;

      if (cfg_we_i) begin
        case (reg_e'(cfg_index_i))
          REG_LAMBDA: regularization_q <= cfg_wdata_i;
          REG_COUNT:  point_count_q    <= cfg_wdata_i[3:0];
          default: ;
        endcase
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (cmd_e'(command_i))
              CMD_CLEAR: begin
                for (int i = 0; i < STATE_DIM; i++) v_q[i] <= '0;
              end
              CMD_PROCESS: begin
                target_q  <= target_next_i;
                pcur_q    <= param_current_i;
                pnext_q   <= param_next_i;
                sat_q     <= 1'b0;
                fault_q   <= 1'b0;
                k_q       <= '0;
                loc_sel_q <= 1'b0;
                n_q       <= (point_count_q > 4'(MODEL_SLOTS)) ? 4'(MODEL_SLOTS)
                                                                : point_count_q;
                if (point_count_q == '0) begin
                  result_q <= '0;
                  empty_q  <= 1'b1;
                  dfault_q <= 1'b0;
                  osat_q   <= 1'b0;
                  done_q   <= 1'b1;
                end else begin
                  state_q <= ST_LOC;
                end
              end
              default: ;
            endcase
          end
        end

        ST_LOC: begin
          if (scan_go) begin
            prev_q <= scan_cur;
            k_q    <= k_q + 1'b1;
          end else begin
            t_q[loc_sel_q] <= '0;
            if (k_q == 4'd0) begin
              lo_q[loc_sel_q] <= '0;
              hi_q[loc_sel_q] <= '0;
            end else if (k_q == n_q) begin
              lo_q[loc_sel_q] <= SLOT_W'(n_q - 1'b1);
              hi_q[loc_sel_q] <= SLOT_W'(n_q - 1'b1);
            end else if (scan_cur == scan_p) begin
              lo_q[loc_sel_q] <= k_q[SLOT_W-1:0];
              hi_q[loc_sel_q] <= k_q[SLOT_W-1:0];
            end else begin
              lo_q[loc_sel_q] <= k_q[SLOT_W-1:0] - 1'b1;
              hi_q[loc_sel_q] <= k_q[SLOT_W-1:0];
            end
            if (scan_div) begin
              state_q <= ST_LOC_DIV;
            end else if (!loc_sel_q) begin
              loc_sel_q <= 1'b1;
              k_q       <= '0;
            end else begin
              off_q   <= '0;
              acc_q   <= '0;
              state_q <= ST_RD_LO;
            end
          end
        end

        ST_LOC_DIV: begin
          if (div_st.done) begin
            t_q[loc_sel_q] <= div_quo[15:0];
            if (!loc_sel_q) begin
              loc_sel_q <= 1'b1;
              k_q       <= '0;
              state_q   <= ST_LOC;
            end else begin
              off_q   <= '0;
              acc_q   <= '0;
              state_q <= ST_RD_LO;
            end
          end
        end

        ST_RD_LO: state_q <= ST_RD_HI;

        ST_RD_HI: begin
          c0_q    <= mem_rdata_q;
          state_q <= ST_LERP_MUL;
        end

        ST_LERP_MUL: state_q <= ST_LERP_ADD;

        ST_LERP_ADD: begin
          coef_q <= coef;
          if (off_q < B_OFF) begin
            state_q <= ST_MAC_MUL;
          end else begin
            if (off_q < C_OFF) bc_q[off_q[1:0]] <= coef;
            else cr_q[off_q[1:0]] <= coef;
            if (off_q == LAST_OFF) begin
              idx_q   <= '0;
              dsel_q  <= 1'b0;
              acc_q   <= '0;
              state_q <= ST_DOT_MUL;
            end else begin
              off_q   <= off_q + 1'b1;
              state_q <= ST_RD_LO;
            end
          end
        end

        ST_MAC_MUL: state_q <= ST_MAC_ADD;

        ST_MAC_ADD: begin
          // The last column of an A row closes that row's entry of A v.
          if (off_q[1:0] == 2'd3) begin
            w_q[off_q[3:2]] <= sat32(acc_new);
            sat_q           <= sat_q | ovf32(acc_new);
            acc_q           <= '0;
          end else begin
            acc_q <= acc_new;
          end
          off_q   <= off_q + 1'b1;
          state_q <= ST_RD_LO;
        end

        ST_DOT_MUL: state_q <= ST_DOT_ADD;

        ST_DOT_ADD: begin
          if (idx_q == 2'd3) begin
            acc_q <= '0;
            idx_q <= '0;
            sat_q <= sat_q | ovf32(acc_new);
            if (!dsel_q) begin
              m_q     <= sat32(acc_new);
              dsel_q  <= 1'b1;
              state_q <= ST_DOT_MUL;
            end else begin
              y_q     <= sat32(acc_new);
              state_q <= ST_BVAL;
            end
          end else begin
            acc_q   <= acc_new;
            idx_q   <= idx_q + 1'b1;
            state_q <= ST_DOT_MUL;
          end
        end

        ST_BVAL: begin
          bv_q    <= sat32(bdiff);
          sat_q   <= sat_q | ovf32(bdiff);
          state_q <= ST_DEN_MUL;
        end

        ST_DEN_MUL: state_q <= ST_NUM_MUL;

        ST_NUM_MUL: begin
          den_q   <= prod[63:0] + (64'(regularization_q) << FRAC_BITS);
          state_q <= ST_DIV_START;
        end

        ST_DIV_START: begin
          neg_q <= pneg;
          idx_q <= '0;
          if (den_q == '0) begin
            fault_q <= 1'b1;
            x_q     <= '0;
            state_q <= ST_UPD_MUL;
          end else begin
            state_q <= ST_DIV_WAIT;
          end
        end

        ST_DIV_WAIT: begin
          if (div_st.done) begin
            if (qbig) begin
              x_q   <= neg_q ? 32'h8000_0000 : 32'h7fff_ffff;
              sat_q <= 1'b1;
            end else begin
              x_q <= neg_q ? (32'd0 - div_quo[31:0]) : div_quo[31:0];
            end
            state_q <= ST_UPD_MUL;
          end
        end

        ST_UPD_MUL: state_q <= ST_UPD_ADD;

        ST_UPD_ADD: begin
          v_q[idx_q] <= sat32(vsum);
          sat_q      <= sat_q | ovf32(vsum);
          if (idx_q == 2'd3) begin
            result_q <= x_q;
            empty_q  <= 1'b0;
            dfault_q <= fault_q;
            osat_q   <= sat_q | ovf32(vsum);
            done_q   <= 1'b1;
            state_q  <= ST_IDLE;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= ST_UPD_MUL;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign done_o           = done_q;
  assign required_input_o = result_q;
  assign table_empty_o    = empty_q;
  assign divide_fault_o   = dfault_q;
  assign saturated_o      = osat_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result shown while a process item still runs");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && command_i != CMD_PROCESS) |=> !done_o)
    else $error("load or clear item produced a result");

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && divide_fault_o) |-> (required_input_o == 32'd0))
    else $error("zero divisor gave a nonzero estimate");

  a_empty_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && table_empty_o) |-> (!divide_fault_o && !saturated_o && required_input_o == 32'd0))
    else $error("empty table result carries flags");

endmodule
